// ===== hw/rtl/ddam_pkg.sv =====
package ddam_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 32;
  localparam int RGB_W      = 24;
  localparam int ALPHA_W    = 8;
  localparam int DICE_W     = 8;
  localparam int IMGW_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd255;
  localparam logic [DICE_W-1:0]  DICE_RESET  = 8'd0;
  localparam logic [IMGW_W-1:0]  IMGW_RESET  = 13'd640;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 2'd0,
    REG_DICE  = 2'd1,
    REG_IMGW  = 2'd2
  } reg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } ddam_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dice_zero;
    logic div_last;
    logic out_free;
  } ddam_stat_t;

endpackage

// ===== hw/rtl/ddam_if.sv =====
interface ddam_cfg_if;
  import ddam_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface ddam_pix_in_if;
  import ddam_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             first_pixel;
  modport source (output valid, output pixel_in, output first_pixel, input ready);
  modport sink   (input valid, input pixel_in, input first_pixel, output ready);
endinterface

interface ddam_pix_out_if;
  import ddam_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== hw/rtl/ddam_ctrl.sv =====
module ddam_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ddam_pkg::ddam_stat_t stat,
  output ddam_pkg::ddam_cmd_t  cmd
);
  import ddam_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    CALC,
    PUSH
  } state_t;

  state_t state;

  always_comb begin
    cmd.load = in_ready && in_valid;
    cmd.step = (state == CALC);
    cmd.push = (state == PUSH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_ready && in_valid) begin
            in_ready <= 1'b0;
            // no division needed when every pixel is selected
            state    <= stat.dice_zero ? PUSH : CALC;
          end
        end
        CALC: begin
          if (stat.div_last) begin
            state <= PUSH;
          end
        end
        PUSH: begin
          if (stat.out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ddam_dp.sv =====
module ddam_dp #(
  parameter int MAX_WIDTH  = ddam_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ddam_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [ddam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddam_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [ddam_pkg::PIX_W-1:0]      pixel_in,
  input  logic                            first_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ddam_pkg::PIX_W-1:0]      pixel_out,
  input  ddam_pkg::ddam_cmd_t             cmd,
  output ddam_pkg::ddam_stat_t            stat
);
  import ddam_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (WW > IMGW_W) ? WW : IMGW_W;
  localparam int SW  = $clog2(MAX_HEIGHT + MAX_WIDTH);
  localparam int NW  = $clog2(SW + 1);

  logic [ALPHA_W-1:0] alpha_byte;
  logic [DICE_W-1:0]  dice_width;
  logic [IMGW_W-1:0]  image_width;
  logic [CW-1:0]      column_count;
  logic [RW-1:0]      row_count;

  logic [RGB_W-1:0]   rgb;
  logic [SW-1:0]      dvd_a, dvd_b;
  logic [DICE_W-1:0]  rem_a, rem_b;
  logic               q_a, q_b;
  logic [NW-1:0]      step_cnt;

  logic [XW-1:0]      iw_ext;
  logic [WW-1:0]      eff_w;
  logic [CW-1:0]      c_cur;
  logic [RW-1:0]      r_cur, r_inc;
  logic [WW-1:0]      c_plus;
  logic [CW-1:0]      col_next;
  logic [RW-1:0]      row_next;
  logic [SW-1:0]      sum_a, sum_b;
  logic [DICE_W:0]    sh_a, sh_b, tr_a, tr_b;

  // clamp the configured width into one..max
  always_comb begin
    iw_ext = XW'(image_width);
    if (iw_ext == '0) begin
      eff_w = WW'(1);
    end else if (iw_ext > XW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = iw_ext[WW-1:0];
    end
  end

  always_comb begin
    r_inc = (row_count < RW'(MAX_HEIGHT - 1)) ? row_count + RW'(1) : row_count;
    if (first_pixel) begin
      c_cur = '0;
      r_cur = '0;
    end else if (WW'(column_count) >= eff_w) begin
      // width lowered mid-row: wrap onto the next row
      c_cur = '0;
      r_cur = r_inc;
    end else begin
      c_cur = column_count;
      r_cur = row_count;
    end
    sum_a  = SW'(r_cur) + SW'(c_cur);
    sum_b  = SW'(r_cur) + SW'(eff_w) - SW'(c_cur);
    c_plus = WW'(c_cur) + WW'(1);
    if (c_plus >= eff_w) begin
      col_next = '0;
      row_next = (r_cur < RW'(MAX_HEIGHT - 1)) ? r_cur + RW'(1) : r_cur;
    end else begin
      col_next = c_plus[CW-1:0];
      row_next = r_cur;
    end
  end

  // one restoring division step for each dividend
  always_comb begin
    sh_a = {rem_a, dvd_a[SW-1]};
    sh_b = {rem_b, dvd_b[SW-1]};
    tr_a = sh_a - {1'b0, dice_width};
    tr_b = sh_b - {1'b0, dice_width};
  end

  always_comb begin
    stat.dice_zero = (dice_width == '0);
    stat.div_last  = (step_cnt == NW'(1));
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_byte   <= ALPHA_RESET;
      dice_width   <= DICE_RESET;
      image_width  <= IMGW_RESET;
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ALPHA: alpha_byte  <= cfg_data[ALPHA_W-1:0];
          REG_DICE:  dice_width  <= cfg_data[DICE_W-1:0];
          REG_IMGW:  image_width <= cfg_data[IMGW_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        column_count <= col_next;
        row_count    <= row_next;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rgb      <= pixel_in[RGB_W-1:0];
      dvd_a    <= sum_a;
      dvd_b    <= sum_b;
      rem_a    <= '0;
      rem_b    <= '0;
      q_a      <= 1'b0;
      q_b      <= 1'b0;
      step_cnt <= NW'(SW);
    end else if (cmd.step) begin
      dvd_a    <= {dvd_a[SW-2:0], 1'b0};
      dvd_b    <= {dvd_b[SW-2:0], 1'b0};
      step_cnt <= step_cnt - NW'(1);
      if (!tr_a[DICE_W]) begin
        rem_a <= tr_a[DICE_W-1:0];
        q_a   <= 1'b1;
      end else begin
        rem_a <= sh_a[DICE_W-1:0];
        q_a   <= 1'b0;
      end
      if (!tr_b[DICE_W]) begin
        rem_b <= tr_b[DICE_W-1:0];
        q_b   <= 1'b1;
      end else begin
        rem_b <= sh_b[DICE_W-1:0];
        q_b   <= 1'b0;
      end
    end
    if (cmd.push) begin
      // quotient parity of the last step picks the checker cell
      if ((dice_width == '0) || (q_a ^ q_b)) begin
        pixel_out <= {alpha_byte, rgb};
      end else begin
        pixel_out <= {ALPHA_W'(0), rgb};
      end
    end
  end

endmodule

// ===== hw/rtl/diagonal_dice_alpha_mask.sv =====
// diagonal dice alpha mask
// pixels arrive in raster order on pix_in (pixel_in, first_pixel) and leave on
// pix_out (pixel_out) with the rgb bits untouched and the alpha byte replaced
// by the configured alpha or zero, in a diagonal checker pattern.
// cfg writes alpha_byte (index 0), dice_width (1) and image_width (2); it is
// always ready and should only be written while no pixel is in flight.
// a pixel with first_pixel set restarts at row 0, column 0.
// one pixel is handled at a time: an accepted request goes through the CALC
// state (skipped when dice_width is zero) and the PUSH state into the output
// register. S is the width of the row+column sum (13 for 4096 x 4096), and in
// CALC the two cell quotients come from a shared-count restoring divider, one
// bit per cycle, over all S bits. the next request is taken once the result
// has been pushed into the output register.
// the output register lets the next pixel be accepted and worked on while a
// result still waits; a stalled receiver holds the result and, once a second
// result is ready, holds the block in its push state until taken.
// reset clears the row and column counters, empties the output register and
// returns the registers to alpha 255, dice width 0, image width 640.
module diagonal_dice_alpha_mask #(
  parameter int MAX_WIDTH  = ddam_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ddam_pkg::MAX_HEIGHT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ddam_cfg_if.sink       cfg,
  ddam_pix_in_if.sink    pix_in,
  ddam_pix_out_if.source pix_out
);
  import ddam_pkg::*;

  ddam_cmd_t  cmd;
  ddam_stat_t stat;

  assign cfg.ready = 1'b1;

  ddam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddam_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .pixel_in    (pix_in.pixel_in),
    .first_pixel (pix_in.first_pixel),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_out   (pix_out.pixel_out),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
